### rtl/twis_pkg.sv
package twis_pkg;

    // Width of the letter field of a request.
    localparam int LETTER_W = 5;

    // Action codes carried by a request.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                action;
        logic [LETTER_W-1:0] letter;
        logic                last_letter;
    } t_in_req;

    typedef struct packed {
        logic found;
        logic pool_full;
    } t_out_res;

    // What one tree step decided for the letter under work.
    typedef struct packed {
        logic alloc;
        logic fail;
    } t_walk_flags;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MARK
    } t_state;

endpackage

### rtl/trie_word_insert_search_top.sv
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_stall  i_in_req  (action, letter, last_letter)
// out       output     o_out_valid / i_out_stall o_out_res (found, pool_full)
//
// A letter reads the node row from the link memory in ST_IDLE, then follows or
// allocates the link in ST_WALK, writing the row back on allocation. A search that
// ends a word also reads the end mark of the final node from the mark memory.
// After reset a clearing pass zeroes both memories, one node row per cycle, with
// o_in_stall held high; reset also returns the cursor to the root and the free
// counter to one. A stalled output only holds back a request that must deliver a
// result; other letters keep flowing while a result waits.
module trie_word_insert_search_top
    import twis_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_res
);

    // Node index width, free counter width (it must reach MAX_NODES itself).
    localparam int NW = $clog2(MAX_NODES);
    localparam int FW = $clog2(MAX_NODES + 1);
    localparam logic [NW-1:0] CLR_LAST = NW'(MAX_NODES - 1);

    t_state        r_state, n_state;
    logic [NW-1:0] r_clr_addr, n_clr_addr;
    logic [NW-1:0] r_cursor, n_cursor;
    logic          r_failed, n_failed;
    logic [FW-1:0] r_free, n_free;
    t_in_req       r_req, n_req;
    logic          r_out_valid, n_out_valid;
    t_out_res      r_out_res, n_out_res;

    // Link memory: one row per node, one child index per letter.
    logic                                link_rd_en;
    logic [NW-1:0]                       link_rd_addr;
    logic [ALPHABET_SIZE-1:0][NW-1:0]    link_rd_row;
    logic                                link_wr_en;
    logic [NW-1:0]                       link_wr_addr;
    logic [ALPHABET_SIZE-1:0][NW-1:0]    link_wr_data;

    // Mark memory: one word-end bit per node.
    logic          mark_rd_en;
    logic [NW-1:0] mark_rd_addr;
    logic          mark_rd_data;
    logic          mark_wr_en;
    logic [NW-1:0] mark_wr_addr;
    logic          mark_wr_data;

    t_walk_flags                      walk_flags;
    logic [NW-1:0]                    walk_cursor;
    logic [ALPHABET_SIZE-1:0][NW-1:0] walk_row;
    logic                             word_fail;
    logic                             out_free;

    twis_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (ALPHABET_SIZE * NW)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_rd_en   (link_rd_en),
        .i_rd_addr (link_rd_addr),
        .o_rd_data (link_rd_row),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (link_wr_addr),
        .i_wr_data (link_wr_data)
    );

    twis_ram #(
        .DEPTH (MAX_NODES),
        .WIDTH (1)
    ) u_mark_ram (
        .i_clk     (i_clk),
        .i_rd_en   (mark_rd_en),
        .i_rd_addr (mark_rd_addr),
        .o_rd_data (mark_rd_data),
        .i_wr_en   (mark_wr_en),
        .i_wr_addr (mark_wr_addr),
        .i_wr_data (mark_wr_data)
    );

    // One step down the tree for the registered request, using the row that
    // was read at the current cursor.
    twis_walk #(
        .MAX_NODES     (MAX_NODES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_walk (
        .i_req    (r_req),
        .i_row    (link_rd_row),
        .i_cursor (r_cursor),
        .i_failed (r_failed),
        .i_free   (r_free),
        .o_flags  (walk_flags),
        .o_cursor (walk_cursor),
        .o_row    (walk_row)
    );

    // The word has failed if it failed earlier or fails at this letter.
    assign word_fail = r_failed || walk_flags.fail;

    // The output register can take a result if it is empty or drains this cycle.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_failed    <= 1'b0;
            r_free      <= FW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_failed    <= n_failed;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_out_res <= n_out_res;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_cursor     = r_cursor;
        n_failed     = r_failed;
        n_free       = r_free;
        n_req        = r_req;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_res    = r_out_res;

        link_rd_en   = 1'b0;
        link_rd_addr = r_cursor;
        link_wr_en   = 1'b0;
        link_wr_addr = r_cursor;
        link_wr_data = walk_row;

        mark_rd_en   = 1'b0;
        mark_rd_addr = walk_cursor;
        mark_wr_en   = 1'b0;
        mark_wr_addr = walk_cursor;
        mark_wr_data = 1'b1;

        unique case (r_state)
            ST_CLEAR: begin
                // Zero one node row of each memory per cycle.
                link_wr_en   = 1'b1;
                link_wr_addr = r_clr_addr;
                link_wr_data = '0;
                mark_wr_en   = 1'b1;
                mark_wr_addr = r_clr_addr;
                mark_wr_data = 1'b0;
                n_clr_addr   = r_clr_addr + NW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // Accepting a request starts the read of the cursor's row.
                if (i_in_valid) begin
                    link_rd_en = 1'b1;
                    n_req      = i_in_req;
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!r_req.last_letter) begin
                    link_wr_en = walk_flags.alloc;
                    if (walk_flags.alloc) begin
                        n_free = r_free + FW'(1);
                    end
                    n_cursor = walk_cursor;
                    n_failed = word_fail;
                    n_state  = ST_IDLE;
                end else if (r_req.action == ACT_SEARCH) begin
                    // The answer needs the end mark of the final node.
                    link_wr_en = walk_flags.alloc;
                    if (walk_flags.alloc) begin
                        n_free = r_free + FW'(1);
                    end
                    mark_rd_en = 1'b1;
                    n_cursor   = walk_cursor;
                    n_failed   = word_fail;
                    n_state    = ST_MARK;
                end else if (out_free) begin
                    // An insert that ends a word marks its node unless it failed.
                    link_wr_en = walk_flags.alloc;
                    if (walk_flags.alloc) begin
                        n_free = r_free + FW'(1);
                    end
                    mark_wr_en          = !word_fail;
                    n_out_valid         = 1'b1;
                    n_out_res.found     = !word_fail;
                    n_out_res.pool_full = word_fail;
                    n_cursor            = '0;
                    n_failed            = 1'b0;
                    n_state             = ST_IDLE;
                end
            end
            ST_MARK: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out_res.found     = !r_failed && mark_rd_data;
                    n_out_res.pool_full = 1'b0;
                    n_cursor            = '0;
                    n_failed            = 1'b0;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

`ifndef SYNTHESIS
    // A node is only handed out while the pool still has one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK && walk_flags.alloc) |-> (r_free < FW'(MAX_NODES)))
        else $error("node allocated from an exhausted pool");

    // The cursor always points at a node that has been handed out.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |-> (FW'(r_cursor) < r_free))
        else $error("cursor beyond the allocated nodes");

    // The free counter never moves backwards once the clearing pass is over.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_CLEAR) |=> (r_free >= $past(r_free)))
        else $error("free counter went backwards");

    // After a search answer the walk restarts at the root with a clean word.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_MARK) |-> (r_cursor == '0 && !r_failed))
        else $error("word state not reset after search result");
`endif

endmodule

### rtl/twis_ram.sv
module twis_ram
    import twis_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/twis_walk.sv
module twis_walk
    import twis_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  t_in_req                                                i_req,
    input  logic [ALPHABET_SIZE-1:0][$clog2(MAX_NODES)-1:0]        i_row,
    input  logic [$clog2(MAX_NODES)-1:0]                           i_cursor,
    input  logic                                                   i_failed,
    input  logic [$clog2(MAX_NODES+1)-1:0]                         i_free,
    output t_walk_flags                                            o_flags,
    output logic [$clog2(MAX_NODES)-1:0]                           o_cursor,
    output logic [ALPHABET_SIZE-1:0][$clog2(MAX_NODES)-1:0]        o_row
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int FW = $clog2(MAX_NODES + 1);
    localparam int LW = $clog2(ALPHABET_SIZE);

    logic [LW-1:0] lidx;
    logic          letter_ok;
    logic          take;
    logic [NW-1:0] child;
    logic          has_child;
    logic          pool_left;
    logic          alloc;

    assign lidx      = LW'(i_req.letter);
    assign letter_ok = int'(i_req.letter) < ALPHABET_SIZE;
    // A failed word and a letter outside the alphabet leave the cursor alone.
    assign take      = !i_failed && letter_ok;
    assign child     = i_row[lidx];
    assign has_child = child != '0;
    assign pool_left = i_free < FW'(MAX_NODES);
    assign alloc     = take && !has_child && (i_req.action == ACT_INSERT) && pool_left;

    assign o_flags.alloc = alloc;
    assign o_flags.fail  = take && !has_child && !alloc;

    always_comb begin
        priority if (take && has_child) begin
            o_cursor = child;
        end else if (alloc) begin
            o_cursor = NW'(i_free);
        end else begin
            o_cursor = i_cursor;
        end
    end

    // Row write-back with the new link patched in; only written on allocation.
    always_comb begin
        o_row       = i_row;
        o_row[lidx] = NW'(i_free);
    end

endmodule
